// File: rtl/core/quantum_rotation_gate_adaptive_top_macros.svh
// Assertion macros shared by the rotation gate RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef QUANTUM_ROTATION_GATE_ADAPTIVE_TOP_MACROS_SVH
`define QUANTUM_ROTATION_GATE_ADAPTIVE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QRG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QRG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/qrg_pkg.sv
// Shared types, constants and the CORDIC arctangent table of the rotation gate.
// No dependencies; used by every module of the block.
`default_nettype none

package qrg_pkg;

    localparam int AMP_W     = 16;
    localparam int FIT_W     = 32;
    localparam int ANG_W     = 16;
    localparam int AMPC_W    = 15;
    localparam int CORDIC_N  = 16;
    localparam int QBITS     = 17;
    localparam int PROD_W    = FIT_W + ANG_W;
    localparam int E_W       = ANG_W + 2;
    localparam int CX_W      = 36;
    localparam int Z_W       = 34;
    localparam int FRONT_ST  = QBITS + 4;
    localparam int BACK_ST   = CORDIC_N + 3;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;
    localparam int CIDX_W    = 3;
    localparam int CDATA_W   = 32;
    localparam logic [15:0] KINV = 16'd39797;

    typedef enum logic [CIDX_W-1:0] {
        CFG_ANGLE_LOW    = 3'd0,
        CFG_ANGLE_HIGH   = 3'd1,
        CFG_FITNESS_MAX  = 3'd2,
        CFG_FITNESS_MIN  = 3'd3,
        CFG_BEST_FITNESS = 3'd4,
        CFG_EPSILON      = 3'd5,
        CFG_AMP_SMALL    = 3'd6,
        CFG_AMP_LARGE    = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_KEEP    = 2'd0,
        ACT_ROTATE  = 2'd1,
        ACT_CLAMP_A = 2'd2,
        ACT_CLAMP_B = 2'd3
    } t_action;

    typedef struct packed {
        logic [ANG_W-1:0]        angle_low;
        logic [ANG_W-1:0]        angle_high;
        logic signed [FIT_W-1:0] fitness_max;
        logic signed [FIT_W-1:0] fitness_min;
        logic signed [FIT_W-1:0] best_fitness;
        logic [15:0]             epsilon;
        logic [AMPC_W-1:0]       amp_small;
        logic [AMPC_W-1:0]       amp_large;
    } t_cfg;

    // One classified qubit handed from the front end to the back end.
    typedef struct packed {
        logic signed [AMP_W-1:0] alpha;
        logic signed [AMP_W-1:0] beta;
        logic                    flat;
        logic signed [E_W-1:0]   angle;
    } t_job;

    // atan(2^-i) scaled by 2^30.
    function automatic logic [Z_W-1:0] atan_q30(input logic [4:0] i);
        logic [Z_W-1:0] v;
        unique case (i)
            5'd0:  v = 34'd843314857;
            5'd1:  v = 34'd497837829;
            5'd2:  v = 34'd263043837;
            5'd3:  v = 34'd133525159;
            5'd4:  v = 34'd67021687;
            5'd5:  v = 34'd33543516;
            5'd6:  v = 34'd16775851;
            5'd7:  v = 34'd8388437;
            5'd8:  v = 34'd4194283;
            5'd9:  v = 34'd2097149;
            5'd10: v = 34'd1048575;
            5'd11: v = 34'd524287;
            5'd12: v = 34'd262143;
            5'd13: v = 34'd131071;
            5'd14: v = 34'd65535;
            5'd15: v = 34'd32767;
            5'd16: v = 34'd16383;
            5'd17: v = 34'd8191;
            5'd18: v = 34'd4095;
            5'd19: v = 34'd2047;
            5'd20: v = 34'd1023;
            5'd21: v = 34'd511;
            5'd22: v = 34'd255;
            5'd23: v = 34'd127;
            5'd24: v = 34'd63;
            5'd25: v = 34'd31;
            5'd26: v = 34'd15;
            5'd27: v = 34'd8;
            5'd28: v = 34'd4;
            5'd29: v = 34'd2;
            5'd30: v = 34'd1;
            5'd31: v = 34'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/qrg_fifo.sv
// Short queue of classified jobs between the front and back ends.
// Depends on qrg_pkg and the shared assertion macro header.
`default_nettype none
`include "quantum_rotation_gate_adaptive_top_macros.svh"

module qrg_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    input  qrg_pkg::t_job      i_push_data,
    output logic               o_pop_valid,
    input  wire logic          i_pop_ready,
    output qrg_pkg::t_job      o_pop_data
);

    qrg_pkg::t_job                r_mem [0:qrg_pkg::QDEPTH-1];
    logic [qrg_pkg::QPTR_W-1:0]   r_wr;
    logic [qrg_pkg::QPTR_W-1:0]   r_rd;
    logic [qrg_pkg::QCNT_W-1:0]   r_count;
    logic                         w_push;
    logic                         w_pop;

    // Handshake decode.
    assign o_push_ready = (r_count != qrg_pkg::QCNT_W'(qrg_pkg::QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `QRG_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= qrg_pkg::QCNT_W'(qrg_pkg::QDEPTH), "queue count beyond depth")
    `QRG_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, w_push && !w_pop, r_count == $past(r_count) + 1'b1, "queue count did not rise on push")
    `QRG_ASSERT_NEXT(a_count_down, i_clk, i_rst_n, w_pop && !w_push, r_count == $past(r_count) - 1'b1, "queue count did not fall on pop")

endmodule

`default_nettype wire

// File: rtl/core/qrg_front.sv
// Front end: accepts qubits, picks the rotation sign and derives the adaptive angle
// through a multiplier and a bit-per-stage restoring divider. Depends on qrg_pkg.
`default_nettype none

module qrg_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  qrg_pkg::t_cfg                      i_cfg,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [qrg_pkg::AMP_W-1:0] i_alpha_in,
    input  wire logic signed [qrg_pkg::AMP_W-1:0] i_beta_in,
    input  wire logic                          i_measured_bit,
    input  wire logic                          i_best_bit,
    input  wire logic signed [qrg_pkg::FIT_W-1:0] i_own_fitness,
    input  wire logic                          i_coin,
    output logic                               o_job_valid,
    input  wire logic                          i_job_ready,
    output qrg_pkg::t_job                      o_job
);

    localparam int NF = qrg_pkg::FRONT_ST;
    localparam int QB = qrg_pkg::QBITS;
    localparam int FW = qrg_pkg::FIT_W;
    localparam int AW = qrg_pkg::ANG_W;

    typedef struct packed {
        logic signed [qrg_pkg::AMP_W-1:0] alpha;
        logic signed [qrg_pkg::AMP_W-1:0] beta;
        logic flat;
        logic inv;
        logic neg;
        logic sz;
        logic sn;
        logic sat;
    } t_fpay;

    logic [NF-1:0]                  r_v;
    t_fpay                          r_pay [0:NF-2];
    logic [FW-1:0]                  r_mag;
    logic [AW-1:0]                  r_smag;
    logic [qrg_pkg::PROD_W-1:0]     r_prod;
    logic [FW-1:0]                  r_rem [0:QB-1];
    logic [QB-1:0]                  r_low [0:QB-1];
    logic [QB-1:0]                  r_q   [0:QB];
    qrg_pkg::t_job                  r_job;

    logic                           w_adv;
    logic signed [FW:0]             w_diff;
    logic [FW:0]                    w_ndiff;
    logic                           w_ge;
    logic signed [AW:0]             w_span;
    logic [AW:0]                    w_nspan;
    logic                           w_flip;
    logic                           w_same;
    t_fpay                          w_pay0;
    t_fpay                          w_pay2;
    logic [FW-1:0]                  w_mag;
    logic [AW-1:0]                  w_smag;
    logic [FW-1:0]                  w_den;
    logic                           w_sat;
    logic [QB:0]                    w_qv;
    logic signed [AW+3:0]           w_th;
    logic [AW-1:0]                  w_th16;
    logic signed [qrg_pkg::E_W-1:0] w_angle;

    // Global stall: the pipe moves whenever its last beat can leave.
    assign w_adv       = !r_v[NF-1] || i_job_ready;
    assign o_ready     = w_adv;
    assign o_job_valid = r_v[NF-1];
    assign o_job       = r_job;
    assign w_den       = FW'(i_cfg.fitness_max - i_cfg.fitness_min);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[NF-2:0], i_valid};
        end
    end

    // Classification: fitness offset, slope sign and rotation sign.
    always_comb begin
        w_diff  = {i_own_fitness[FW-1], i_own_fitness}
                - {i_cfg.fitness_min[FW-1], i_cfg.fitness_min};
        w_ndiff = -w_diff;
        w_ge    = !w_diff[FW];
        w_mag   = w_ge ? w_diff[FW-1:0] : w_ndiff[FW-1:0];
        w_span  = $signed({1'b0, i_cfg.angle_high}) - $signed({1'b0, i_cfg.angle_low});
        w_nspan = -w_span;
        w_smag  = w_span[AW] ? w_nspan[AW-1:0] : w_span[AW-1:0];
        w_flip  = i_measured_bit != ($signed(i_own_fitness) >= $signed(i_cfg.best_fitness));
        w_same  = (i_alpha_in > 0) == (i_beta_in > 0);

        w_pay0       = '0;
        w_pay0.alpha = i_alpha_in;
        w_pay0.beta  = i_beta_in;
        w_pay0.flat  = (i_cfg.fitness_max == i_cfg.fitness_min);
        w_pay0.inv   = ($signed(i_cfg.fitness_max) < $signed(i_cfg.fitness_min));
        w_pay0.neg   = (!w_ge) ^ w_span[AW];
        w_pay0.sz    = 1'b1;
        w_pay0.sn    = 1'b0;
        if (i_measured_bit != i_best_bit) begin
            if (i_alpha_in != 0 && i_beta_in != 0) begin
                w_pay0.sz = 1'b0;
                w_pay0.sn = w_same ? w_flip : !w_flip;
            end else if (i_alpha_in == 0) begin
                w_pay0.sz = !w_flip;
                w_pay0.sn = !i_coin;
            end else begin
                w_pay0.sz = w_flip;
                w_pay0.sn = !i_coin;
            end
        end
    end

    // Capture, product and saturation check.
    assign w_sat = {1'b0, r_prod} >= {w_den, QB'(0)};

    always_comb begin
        w_pay2     = r_pay[1];
        w_pay2.sat = w_sat;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pay[0]     <= w_pay0;
            r_mag        <= w_mag;
            r_smag       <= w_smag;
            r_pay[1]     <= r_pay[0];
            r_prod       <= qrg_pkg::PROD_W'(r_mag) * qrg_pkg::PROD_W'(r_smag);
            r_pay[2]     <= w_pay2;
            r_rem[0]     <= {1'b0, r_prod[qrg_pkg::PROD_W-1:QB]};
            r_low[0]     <= r_prod[QB-1:0];
            r_q[0]       <= '0;
        end
    end

    // Restoring divider, one quotient bit per stage.
    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [FW:0] w_sh;
        logic [FW:0] w_sub;
        logic        w_bit;

        assign w_sh  = {r_rem[k], r_low[k][QB-1]};
        assign w_sub = w_sh - {1'b0, w_den};
        assign w_bit = (w_sh >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_pay[3+k] <= r_pay[2+k];
                r_q[k+1]   <= {r_q[k][QB-2:0], w_bit};
            end
        end

        if (k < QB-1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_rem[k+1] <= w_bit ? w_sub[FW-1:0] : w_sh[FW-1:0];
                    r_low[k+1] <= {r_low[k][QB-2:0], 1'b0};
                end
            end
        end
    end

    // Angle assembly with saturation to the Q0.16 range.
    always_comb begin
        w_qv = r_pay[NF-2].sat ? {1'b1, QB'(0)} : {1'b0, r_q[QB]};
        if (r_pay[NF-2].neg) begin
            w_th = $signed({4'b0, i_cfg.angle_low}) - $signed({2'b0, w_qv});
        end else begin
            w_th = $signed({4'b0, i_cfg.angle_low}) + $signed({2'b0, w_qv});
        end
        if (w_th < 0) begin
            w_th16 = '0;
        end else if (w_th > $signed((AW+4)'(20'hFFFF))) begin
            w_th16 = '1;
        end else begin
            w_th16 = w_th[AW-1:0];
        end
        if (r_pay[NF-2].inv) begin
            w_th16 = i_cfg.angle_low;
        end
        if (r_pay[NF-2].flat || r_pay[NF-2].sz) begin
            w_angle = '0;
        end else if (r_pay[NF-2].sn) begin
            w_angle = -$signed({2'b0, w_th16});
        end else begin
            w_angle = $signed({2'b0, w_th16});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_job.alpha <= r_pay[NF-2].alpha;
            r_job.beta  <= r_pay[NF-2].beta;
            r_job.flat  <= r_pay[NF-2].flat;
            r_job.angle <= w_angle;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/qrg_back.sv
// Back end: H-epsilon clamp decision and a pipelined CORDIC rotator with rounding.
// Depends on qrg_pkg.
`default_nettype none

module qrg_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  qrg_pkg::t_cfg                      i_cfg,
    input  wire logic                          i_job_valid,
    output logic                               o_job_ready,
    input  qrg_pkg::t_job                      i_job,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [qrg_pkg::AMP_W-1:0]   o_alpha_out,
    output logic signed [qrg_pkg::AMP_W-1:0]   o_beta_out,
    output logic [1:0]                         o_action
);

    localparam int NB = qrg_pkg::BACK_ST;
    localparam int N  = qrg_pkg::CORDIC_N;
    localparam int CW = qrg_pkg::CX_W;
    localparam int ZW = qrg_pkg::Z_W;
    localparam int AW = qrg_pkg::AMP_W;

    typedef struct packed {
        logic signed [AW-1:0] alpha;
        logic signed [AW-1:0] beta;
        logic                 flat;
        logic                 rot;
        qrg_pkg::t_action     act;
    } t_bpay;

    logic [NB-1:0]          r_v;
    t_bpay                  r_bp [0:N+1];
    logic [31:0]            r_a2;
    logic [31:0]            r_b2;
    logic signed [CW-1:0]   r_cx0;
    logic signed [CW-1:0]   r_cy0;
    logic signed [ZW-1:0]   r_z0;
    logic signed [CW-1:0]   r_cx [0:N];
    logic signed [CW-1:0]   r_cy [0:N];
    logic signed [ZW-1:0]   r_z  [0:N];
    logic signed [AW-1:0]   r_alpha;
    logic signed [AW-1:0]   r_beta;
    logic [1:0]             r_act;

    logic                   w_adv;
    logic signed [31:0]     w_a2;
    logic signed [31:0]     w_b2;
    t_bpay                  w_bp0;
    t_bpay                  w_bp1;
    logic [30:0]            w_lo;
    logic [30:0]            w_hi;
    logic                   w_ca;
    logic                   w_cb;
    qrg_pkg::t_action       w_act;
    logic signed [AW-1:0]   w_rx;
    logic signed [AW-1:0]   w_ry;
    logic signed [AW-1:0]   w_na;
    logic signed [AW-1:0]   w_nb;

    // Round half up, then saturate to the amplitude width.
    function automatic logic signed [AW-1:0] round_sat(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] s;
        logic signed [CW-1:0] r;
        s = v + CW'(32768);
        r = s >>> 16;
        if (r > $signed(CW'(32767))) begin
            return AW'(32767);
        end else if (r < -$signed(CW'(32768))) begin
            return AW'(-32768);
        end
        return r[AW-1:0];
    endfunction

    assign w_adv       = !r_v[NB-1] || i_ready;
    assign o_job_ready = w_adv;
    assign o_valid     = r_v[NB-1];
    assign o_alpha_out = r_alpha;
    assign o_beta_out  = r_beta;
    assign o_action    = r_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[NB-2:0], i_job_valid};
        end
    end

    // Squares for the clamp test and prescaled CORDIC inputs.
    always_comb begin
        w_a2        = i_job.alpha * i_job.alpha;
        w_b2        = i_job.beta * i_job.beta;
        w_bp0.alpha = i_job.alpha;
        w_bp0.beta  = i_job.beta;
        w_bp0.flat  = i_job.flat;
        w_bp0.rot   = (i_job.angle != 0);
        w_bp0.act   = qrg_pkg::ACT_KEEP;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_bp[0] <= w_bp0;
            r_a2    <= w_a2;
            r_b2    <= w_b2;
            r_cx0   <= i_job.alpha * $signed({1'b0, qrg_pkg::KINV});
            r_cy0   <= i_job.beta * $signed({1'b0, qrg_pkg::KINV});
            r_z0    <= {{(ZW-qrg_pkg::E_W-14){i_job.angle[qrg_pkg::E_W-1]}},
                        i_job.angle, 14'b0};
        end
    end

    // Clamp decision against epsilon and one minus epsilon.
    always_comb begin
        w_lo = {1'b0, i_cfg.epsilon, 14'b0};
        w_hi = {(17'h10000 - {1'b0, i_cfg.epsilon}), 14'b0};
        w_ca = (r_a2 <= {1'b0, w_lo}) && (r_b2 >= {1'b0, w_hi});
        w_cb = (r_b2 <= {1'b0, w_lo}) && (r_a2 >= {1'b0, w_hi});
        priority if (r_bp[0].flat) begin
            w_act = qrg_pkg::ACT_KEEP;
        end else if (r_bp[0].rot) begin
            w_act = qrg_pkg::ACT_ROTATE;
        end else if (w_ca) begin
            w_act = qrg_pkg::ACT_CLAMP_A;
        end else if (w_cb) begin
            w_act = qrg_pkg::ACT_CLAMP_B;
        end else begin
            w_act = qrg_pkg::ACT_KEEP;
        end
        w_bp1     = r_bp[0];
        w_bp1.act = w_act;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_bp[1]     <= w_bp1;
            r_cx[0]     <= r_cx0;
            r_cy[0]     <= r_cy0;
            r_z[0]      <= r_z0;
        end
    end

    // CORDIC rotation, one micro-rotation per stage.
    for (genvar i = 0; i < N; i++) begin : g_cordic
        logic signed [CW-1:0] w_dx;
        logic signed [CW-1:0] w_dy;
        logic signed [ZW-1:0] w_at;

        assign w_dx = r_cy[i] >>> i;
        assign w_dy = r_cx[i] >>> i;
        assign w_at = $signed(qrg_pkg::atan_q30(5'(i)));

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_bp[i+2] <= r_bp[i+1];
                if (!r_z[i][ZW-1]) begin
                    r_cx[i+1] <= r_cx[i] - w_dx;
                    r_cy[i+1] <= r_cy[i] + w_dy;
                    r_z[i+1]  <= r_z[i] - w_at;
                end else begin
                    r_cx[i+1] <= r_cx[i] + w_dx;
                    r_cy[i+1] <= r_cy[i] - w_dy;
                    r_z[i+1]  <= r_z[i] + w_at;
                end
            end
        end
    end

    // Result selection.
    always_comb begin
        w_rx = round_sat(r_cx[N]);
        w_ry = round_sat(r_cy[N]);
        unique case (r_bp[N+1].act)
            qrg_pkg::ACT_ROTATE: begin
                w_na = w_rx;
                w_nb = w_ry;
            end
            qrg_pkg::ACT_CLAMP_A: begin
                w_na = $signed({1'b0, i_cfg.amp_small});
                w_nb = $signed({1'b0, i_cfg.amp_large});
            end
            qrg_pkg::ACT_CLAMP_B: begin
                w_na = $signed({1'b0, i_cfg.amp_large});
                w_nb = $signed({1'b0, i_cfg.amp_small});
            end
            default: begin
                w_na = r_bp[N+1].alpha;
                w_nb = r_bp[N+1].beta;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_alpha <= w_na;
            r_beta  <= w_nb;
            r_act   <= r_bp[N+1].act;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/quantum_rotation_gate_adaptive_top.sv
// Adaptive rotation gate, top level: configuration registers, front end, queue, back end.
// Throughput: one qubit per cycle; both halves are fully pipelined with a global stall each.
// The 21-stage front end (17-stage divider), the queue and the 19-stage back end
// (16-stage CORDIC) set the depth. Reset (synchronous, active low) empties both pipes and
// the queue and loads register defaults. Depends on qrg_pkg, qrg_front, qrg_fifo, qrg_back.
`default_nettype none

module quantum_rotation_gate_adaptive_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [qrg_pkg::CIDX_W-1:0]         i_cfg_index,
    input  wire logic [qrg_pkg::CDATA_W-1:0]        i_cfg_data,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [qrg_pkg::AMP_W-1:0]   i_alpha_in,
    input  wire logic signed [qrg_pkg::AMP_W-1:0]   i_beta_in,
    input  wire logic                               i_measured_bit,
    input  wire logic                               i_best_bit,
    input  wire logic signed [qrg_pkg::FIT_W-1:0]   i_own_fitness,
    input  wire logic                               i_coin,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic signed [qrg_pkg::AMP_W-1:0]        o_alpha_out,
    output logic signed [qrg_pkg::AMP_W-1:0]        o_beta_out,
    output logic [1:0]                              o_action
);

    qrg_pkg::t_cfg r_cfg;
    qrg_pkg::t_job w_fjob;
    qrg_pkg::t_job w_bjob;
    logic          w_fvalid;
    logic          w_fready;
    logic          w_bvalid;
    logic          w_bready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angle_low    <= 16'd206;
            r_cfg.angle_high   <= 16'd10294;
            r_cfg.fitness_max  <= '0;
            r_cfg.fitness_min  <= '0;
            r_cfg.best_fitness <= '0;
            r_cfg.epsilon      <= 16'd66;
            r_cfg.amp_small    <= 15'd1036;
            r_cfg.amp_large    <= 15'd32751;
        end else if (i_cfg_we) begin
            unique case (qrg_pkg::t_cfg_idx'(i_cfg_index))
                qrg_pkg::CFG_ANGLE_LOW:    r_cfg.angle_low    <= i_cfg_data[15:0];
                qrg_pkg::CFG_ANGLE_HIGH:   r_cfg.angle_high   <= i_cfg_data[15:0];
                qrg_pkg::CFG_FITNESS_MAX:  r_cfg.fitness_max  <= i_cfg_data;
                qrg_pkg::CFG_FITNESS_MIN:  r_cfg.fitness_min  <= i_cfg_data;
                qrg_pkg::CFG_BEST_FITNESS: r_cfg.best_fitness <= i_cfg_data;
                qrg_pkg::CFG_EPSILON:      r_cfg.epsilon      <= i_cfg_data[15:0];
                qrg_pkg::CFG_AMP_SMALL:    r_cfg.amp_small    <= i_cfg_data[14:0];
                qrg_pkg::CFG_AMP_LARGE:    r_cfg.amp_large    <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    qrg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_alpha_in     (i_alpha_in),
        .i_beta_in      (i_beta_in),
        .i_measured_bit (i_measured_bit),
        .i_best_bit     (i_best_bit),
        .i_own_fitness  (i_own_fitness),
        .i_coin         (i_coin),
        .o_job_valid    (w_fvalid),
        .i_job_ready    (w_fready),
        .o_job          (w_fjob)
    );

    qrg_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fvalid),
        .o_push_ready (w_fready),
        .i_push_data  (w_fjob),
        .o_pop_valid  (w_bvalid),
        .i_pop_ready  (w_bready),
        .o_pop_data   (w_bjob)
    );

    qrg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (w_bvalid),
        .o_job_ready (w_bready),
        .i_job       (w_bjob),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_alpha_out (o_alpha_out),
        .o_beta_out  (o_beta_out),
        .o_action    (o_action)
    );

endmodule

`default_nettype wire

// File: sim/quantum_rotation_gate_adaptive_top_tb.sv
// Self-checking testbench for the adaptive qubit rotation gate.
// Drives valid/ready beats with a fitness-scaled predictor and an in-order scoreboard.
// Depends on qrg_pkg and quantum_rotation_gate_adaptive_top.
`timescale 1ns / 1ps

module quantum_rotation_gate_adaptive_top_tb;

    typedef struct {
        logic signed [qrg_pkg::AMP_W-1:0] alpha;
        logic signed [qrg_pkg::AMP_W-1:0] beta;
        qrg_pkg::t_action                 action;
    } t_qubit_result;

    // Holds a copy of the registers, predicts each updated qubit and keeps them in order.
    class qubit_scoreboard;
        logic [15:0]         angle_low = 16'd206, angle_high = 16'd10294, epsilon = 16'd66;
        logic [14:0]         amp_small = 15'd1036, amp_large = 15'd32751;
        logic signed [31:0]  fit_max = 0, fit_min = 0, best_fit = 0;
        t_qubit_result       pending_q[$];
        int                  n_rotate, n_clamp, n_keep;

        function void set_reg(qrg_pkg::t_cfg_idx idx, logic [31:0] d);
            case (idx)
                qrg_pkg::CFG_ANGLE_LOW:    angle_low = d[15:0];
                qrg_pkg::CFG_ANGLE_HIGH:   angle_high = d[15:0];
                qrg_pkg::CFG_FITNESS_MAX:  fit_max = d;
                qrg_pkg::CFG_FITNESS_MIN:  fit_min = d;
                qrg_pkg::CFG_BEST_FITNESS: best_fit = d;
                qrg_pkg::CFG_EPSILON:      epsilon = d[15:0];
                qrg_pkg::CFG_AMP_SMALL:    amp_small = d[14:0];
                qrg_pkg::CFG_AMP_LARGE:    amp_large = d[14:0];
                default: ;
            endcase
        endfunction

        // Adaptive angle: low + (fit - min) * (high - low) / (max - min), saturated.
        function longint fitness_angle(longint fit);
            longint den, mag, smag, span, q, th;
            bit     neg;
            if (fit_max < fit_min) return angle_low;
            den = longint'(fit_max) - longint'(fit_min);
            if (fit >= fit_min) begin
                mag = fit - fit_min;
                neg = 0;
            end else begin
                mag = fit_min - fit;
                neg = 1;
            end
            span = longint'(angle_high) - longint'(angle_low);
            if (span < 0) begin
                smag = -span;
                neg = !neg;
            end else begin
                smag = span;
            end
            q = (mag * smag) / den;
            if (q > (1 << 20)) q = 1 << 20;
            th = neg ? longint'(angle_low) - q : longint'(angle_low) + q;
            if (th < 0) th = 0;
            if (th > 65535) th = 65535;
            return th;
        endfunction

        function longint round_amp(longint v);
            longint r;
            r = (v + 32768) >>> 16;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r;
        endfunction

        function void note_input(logic signed [15:0] a_in, logic signed [15:0] b_in,
                                 bit meas, bit best, logic signed [31:0] fit, bit coin);
            t_qubit_result r;
            longint a, b, th, e, cx, cy, z, dx, dy, a2, b2, eps_sq, one_sq;
            int     s;
            bit     flip, same;
            a = a_in;
            b = b_in;
            r.alpha = a_in;
            r.beta = b_in;
            r.action = qrg_pkg::ACT_KEEP;
            s = 0;
            if (fit_max != fit_min) begin
                th = fitness_angle(fit);
                if (meas != best) begin
                    flip = (meas == 1'b1) != (fit >= best_fit);
                    same = (a > 0) == (b > 0);
                    if (a != 0 && b != 0) s = same ? (flip ? -1 : 1) : (flip ? 1 : -1);
                    else if (a == 0) s = flip ? (coin ? 1 : -1) : 0;
                    else s = flip ? 0 : (coin ? 1 : -1);
                end
                e = s * th;
                if (e == 0) begin
                    // H-epsilon clamp: squares are Q0.30, thresholds Q0.16.
                    a2 = a * a;
                    b2 = b * b;
                    eps_sq = longint'(epsilon) << 14;
                    one_sq = (65536 - longint'(epsilon)) << 14;
                    if (a2 <= eps_sq && b2 >= one_sq) begin
                        r.alpha = amp_small;
                        r.beta = amp_large;
                        r.action = qrg_pkg::ACT_CLAMP_A;
                    end else if (b2 <= eps_sq && a2 >= one_sq) begin
                        r.alpha = amp_large;
                        r.beta = amp_small;
                        r.action = qrg_pkg::ACT_CLAMP_B;
                    end
                end else begin
                    cx = a * 39797;
                    cy = b * 39797;
                    z = e * 16384;
                    for (int i = 0; i < qrg_pkg::CORDIC_N; i++) begin
                        dx = cy >>> i;
                        dy = cx >>> i;
                        if (z >= 0) begin
                            cx -= dx;
                            cy += dy;
                            z -= longint'(qrg_pkg::atan_q30(5'(i)));
                        end else begin
                            cx += dx;
                            cy -= dy;
                            z += longint'(qrg_pkg::atan_q30(5'(i)));
                        end
                    end
                    r.alpha = 16'(round_amp(cx));
                    r.beta = 16'(round_amp(cy));
                    r.action = qrg_pkg::ACT_ROTATE;
                end
            end
            case (r.action)
                qrg_pkg::ACT_ROTATE: n_rotate++;
                qrg_pkg::ACT_KEEP:   n_keep++;
                default:             n_clamp++;
            endcase
            pending_q.insert(pending_q.size(), r);
        endfunction

        // Returns an empty string on a match, otherwise a description of the mismatch.
        function string check_result(logic signed [15:0] a, logic signed [15:0] b,
                                     logic [1:0] act);
            t_qubit_result r;
            if (pending_q.size() == 0)
                return $sformatf("unexpected result beat a=%0d b=%0d act=%0d", a, b, act);
            r = pending_q[0];
            pending_q.delete(0);
            if (a !== r.alpha || b !== r.beta || act !== r.action)
                return $sformatf("got a=%0d b=%0d act=%0d, want a=%0d b=%0d act=%0d",
                                 a, b, act, r.alpha, r.beta, r.action);
            return "";
        endfunction
    endclass

    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 5000;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [qrg_pkg::CIDX_W-1:0]       i_cfg_index = '0;
    logic [qrg_pkg::CDATA_W-1:0]      i_cfg_data = '0;
    logic                             i_valid = 1'b0;
    logic                             o_ready;
    logic signed [qrg_pkg::AMP_W-1:0] i_alpha_in = '0;
    logic signed [qrg_pkg::AMP_W-1:0] i_beta_in = '0;
    logic                             i_measured_bit = 1'b0;
    logic                             i_best_bit = 1'b0;
    logic signed [qrg_pkg::FIT_W-1:0] i_own_fitness = '0;
    logic                             i_coin = 1'b0;
    logic                             o_valid;
    logic                             i_ready = 1'b0;
    logic signed [qrg_pkg::AMP_W-1:0] o_alpha_out;
    logic signed [qrg_pkg::AMP_W-1:0] o_beta_out;
    logic [1:0]                       o_action;

    qubit_scoreboard sb = new();
    int  fail_count = 0;
    int  in_beats = 0, out_beats = 0;
    int  send_idle_pct = 0, recv_stall_pct = 0;
    int  quiet_cycles = 0;

    quantum_rotation_gate_adaptive_top dut (.*);

    always #2 i_clk = ~i_clk;

    task automatic report(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Input and output beat monitor, sampled at the rising edge.
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && i_valid && o_ready) begin
            sb.note_input(i_alpha_in, i_beta_in, i_measured_bit, i_best_bit,
                          i_own_fitness, i_coin);
            in_beats++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            msg = sb.check_result(o_alpha_out, o_beta_out, o_action);
            if (msg != "") report(msg);
            out_beats++;
        end
    end

    // Receiver back-pressure.
    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog on cycles without any beat.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired: no beat for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_regs(logic [31:0] v[8]);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= qrg_pkg::CIDX_W'(i);
            i_cfg_data <= v[i];
            @(posedge i_clk);
            sb.set_reg(qrg_pkg::t_cfg_idx'(i), v[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every expected qubit has come back and the pipe has settled.
    task automatic drain();
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One input beat: optional idle gap, then hold valid until accepted.
    task automatic send_qubit(logic signed [15:0] a, logic signed [15:0] b, bit meas,
                              bit best, logic signed [31:0] fit, bit coin);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_alpha_in <= a;
        i_beta_in <= b;
        i_measured_bit <= meas;
        i_best_bit <= best;
        i_own_fitness <= fit;
        i_coin <= coin;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic end_stream();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_amp(logic [15:0] eps);
        int unsigned sel;
        int          lim;
        sel = $urandom_range(9);
        lim = 1;
        while (lim * lim <= (int'(eps) << 14) && lim < 32767) lim++;
        case (sel)
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sd0;
            3: return 16'(16'($urandom_range(0, lim)) * ($urandom_range(1) ? 1 : -1));
            4: return 16'(16'(32767 - $urandom_range(0, 300)) * ($urandom_range(1) ? 1 : -1));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_fitness();
        logic signed [31:0] span;
        span = sb.fit_max - sb.fit_min;
        case ($urandom_range(7))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return sb.best_fit;
            3: return 32'($urandom);
            default: begin
                if (sb.fit_max > sb.fit_min && span > 0)
                    return sb.fit_min + 32'($urandom_range(0, span));
                return 32'($urandom);
            end
        endcase
    endfunction

    initial begin
        logic [31:0] regs[8];
        logic signed [15:0] a;
        int n_phase;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values give a flat generation, so every qubit passes through.
        send_qubit(16'sd1234, -16'sd5678, 1'b1, 1'b0, 32'sd5, 1'b1);
        send_qubit(16'sh8000, 16'sh7FFF, 1'b0, 1'b1, -32'sd5, 1'b0);
        end_stream();
        drain();

        // Directed part: sign table, zero amplitudes, clamps, fitness extremes.
        regs = '{32'd206, 32'd10294, 32'd1000, -32'sd1000, 32'd0, 32'd66, 32'd1036, 32'd32751};
        write_regs(regs);
        send_qubit(16'sd20000, 16'sd20000, 1'b1, 1'b0, 32'sd500, 1'b0);
        send_qubit(16'sd20000, -16'sd20000, 1'b1, 1'b0, -32'sd500, 1'b0);
        send_qubit(-16'sd20000, 16'sd20000, 1'b0, 1'b1, 32'sd500, 1'b1);
        send_qubit(-16'sd20000, -16'sd20000, 1'b0, 1'b1, -32'sd500, 1'b1);
        send_qubit(16'sd0, 16'sd30000, 1'b1, 1'b0, -32'sd10, 1'b1);
        send_qubit(16'sd0, 16'sd30000, 1'b1, 1'b0, 32'sd10, 1'b0);
        send_qubit(16'sd0, 16'sd30000, 1'b0, 1'b1, 32'sd10, 1'b1);
        send_qubit(16'sd30000, 16'sd0, 1'b1, 1'b0, 32'sd10, 1'b1);
        send_qubit(16'sd30000, 16'sd0, 1'b0, 1'b1, 32'sd10, 1'b0);
        send_qubit(16'sd100, 16'sh7FFF, 1'b1, 1'b1, 32'sd0, 1'b0);
        send_qubit(-16'sd100, 16'sh8000, 1'b0, 1'b0, 32'sd0, 1'b1);
        send_qubit(16'sh7FFF, 16'sd50, 1'b1, 1'b1, 32'sd0, 1'b0);
        send_qubit(16'sh8000, 16'sd0, 1'b0, 1'b0, 32'sd0, 1'b0);
        send_qubit(16'sd0, 16'sd0, 1'b0, 1'b0, 32'sd0, 1'b0);
        send_qubit(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0, 32'sh7FFFFFFF, 1'b1);
        send_qubit(16'sh8000, 16'sh8000, 1'b1, 1'b0, 32'sh80000000, 1'b1);
        send_qubit(16'sh8000, 16'sh7FFF, 1'b0, 1'b1, 32'sd1000, 1'b0);
        send_qubit(16'sh7FFF, 16'sh8000, 1'b0, 1'b1, -32'sd1000, 1'b1);
        end_stream();
        drain();

        // Random part: register settings change between phases, idling mode rotates.
        n_phase = 0;
        for (int p = 0; p < 12; p++) begin
            case (p % 6)
                0: regs = '{32'd206, 32'd10294, 32'd1000, 32'd0, 32'd500,
                            32'd66, 32'd1036, 32'd32751};
                1: regs = '{32'd0, 32'd65535, 32'h7FFFFFFF, 32'h80000000, 32'd0,
                            32'd65535, 32'd0, 32'd32767};
                2: regs = '{32'd60000, 32'd100, -32'sd5, 32'd5, 32'd0,
                            32'd0, 32'd32767, 32'd0};
                3: regs = '{32'd500, 32'd3000, 32'd77, 32'd77, 32'd77,
                            32'd600, 32'd6270, 32'd32163};
                4: regs = '{$urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom};
                default: regs = '{32'd65535, 32'd65535, 32'd10, 32'd0, 32'd5,
                                  32'd6000, 32'd32767, 32'd0};
            endcase
            write_regs(regs);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            for (int k = 0; k < 100; k++) begin
                a = pick_amp(sb.epsilon);
                send_qubit(a, pick_amp(sb.epsilon), 1'($urandom), 1'($urandom),
                           pick_fitness(), 1'($urandom));
            end
            end_stream();
            send_idle_pct = 0;
            recv_stall_pct = 0;
            drain();
            n_phase++;
        end

        $display("Covered %0d register phases, %0d qubits in and %0d out.",
                 n_phase, in_beats, out_beats);
        $display("Outcomes: %0d rotated, %0d clamped, %0d unchanged.",
                 sb.n_rotate, sb.n_clamp, sb.n_keep);
        if (fail_count == 0 && sb.pending_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
